>>> sv/crcfb_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte update for the frame builder.
// Used by the front end, the job queue, the back end and the top level.
// No dependencies.
`default_nettype none

package crcfb_pkg;

   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [15:0] CRC_POLY       = 16'hA001;
   localparam logic [7:0]  MARK_A         = 8'hD5;
   localparam logic [7:0]  MARK_B         = 8'h5D;
   localparam logic [16:0] FRAME_OVERHEAD = 17'd8;
   localparam logic [15:0] CAPACITY_RESET = 16'd128;
   localparam int          QUEUE_DEPTH_DEFAULT = 4;

   // Item kinds on the input channel's tuser.
   localparam logic OP_START   = 1'b0;
   localparam logic OP_PAYLOAD = 1'b1;

   // Positions in the emitted byte sequence of one frame.
   localparam logic [2:0] STEP_HEAD_A = 3'd0;
   localparam logic [2:0] STEP_HEAD_B = 3'd1;
   localparam logic [2:0] STEP_BYTE0  = 3'd2;
   localparam logic [2:0] STEP_BYTE1  = 3'd3;
   localparam logic [2:0] STEP_CRC_LO = 3'd4;
   localparam logic [2:0] STEP_CRC_HI = 3'd5;
   localparam logic [2:0] STEP_TAIL_A = 3'd6;
   localparam logic [2:0] STEP_TAIL_B = 3'd7;

   typedef enum logic [2:0] {
      JOB_REJECT,
      JOB_OPEN,
      JOB_OPEN_CLOSE,
      JOB_BYTE,
      JOB_BYTE_CLOSE
   } job_kind_type;

   // One queued job: a payload byte travels in byte1.
   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   byte0;
      logic [7:0]   byte1;
      logic [15:0]  crc;
   } job_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
      logic [15:0] c;
      c = crc_in ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

>>> sv/crcfb_front.sv
// Front end of the frame builder (uses crcfb_pkg): holds the capacity register and
// frame state and turns each start beat or open-frame payload beat into one job.
`default_nettype none

module crcfb_front
   import crcfb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        accept,
   input  wire logic        opcode,
   input  wire logic [7:0]  command,
   input  wire logic [7:0]  message_type,
   input  wire logic [15:0] payload_length,
   input  wire logic [7:0]  data_byte,
   output logic             push,
   output job_type          job
);

   logic [15:0] capacity_ff, capacity_in;
   logic        frame_open_ff, frame_open_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] remaining_ff, remaining_in;

   logic [15:0] start_crc;
   logic [15:0] byte_crc;
   logic [15:0] remaining_dec;
   logic [16:0] total_length;

   assign start_crc     = crc_byte(crc_byte(CRC_INIT, command), message_type);
   assign byte_crc      = crc_byte(crc_ff, data_byte);
   assign remaining_dec = remaining_ff - 16'd1;
   assign total_length  = {1'b0, payload_length} + FRAME_OVERHEAD;

   always_comb begin
      capacity_in   = csr_we ? csr_wdata : capacity_ff;
      frame_open_in = frame_open_ff;
      crc_in        = crc_ff;
      remaining_in  = remaining_ff;
      push          = 1'b0;
      job.kind      = JOB_REJECT;
      job.byte0     = command;
      job.byte1     = message_type;
      job.crc       = start_crc;
      if (accept) begin
         if (opcode == OP_START) begin
            push = 1'b1;
            if (total_length > {1'b0, capacity_ff}) begin
               job.kind      = JOB_REJECT;
               frame_open_in = 1'b0;
               crc_in        = CRC_INIT;
               remaining_in  = '0;
            end else if (payload_length == '0) begin
               job.kind      = JOB_OPEN_CLOSE;
               frame_open_in = 1'b0;
               crc_in        = CRC_INIT;
               remaining_in  = '0;
            end else begin
               job.kind      = JOB_OPEN;
               frame_open_in = 1'b1;
               crc_in        = start_crc;
               remaining_in  = payload_length;
            end
         end else if (frame_open_ff) begin
            push      = 1'b1;
            job.byte1 = data_byte;
            job.crc   = byte_crc;
            if (remaining_dec == '0) begin
               job.kind      = JOB_BYTE_CLOSE;
               frame_open_in = 1'b0;
               crc_in        = CRC_INIT;
               remaining_in  = '0;
            end else begin
               job.kind     = JOB_BYTE;
               crc_in       = byte_crc;
               remaining_in = remaining_dec;
            end
         end
         // A payload beat with no frame open is taken and dropped.
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff   <= CAPACITY_RESET;
         frame_open_ff <= 1'b0;
         crc_ff        <= CRC_INIT;
         remaining_ff  <= '0;
      end else begin
         capacity_ff   <= capacity_in;
         frame_open_ff <= frame_open_in;
         crc_ff        <= crc_in;
         remaining_ff  <= remaining_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/crcfb_queue.sv
// Small job queue between the front and back ends of the frame builder.
// Depth is a power of two of at least two. Uses crcfb_pkg for the job type.
`default_nettype none

module crcfb_queue
   import crcfb_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output logic         full,
   output logic         empty,
   output job_type      head
);

   localparam int AW = $clog2(DEPTH);

   job_type        entry_ff [DEPTH];
   logic [AW:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW:0]    rd_ptr_ff, rd_ptr_in;

   assign empty = (wr_ptr_ff == rd_ptr_ff);
   assign full  = (wr_ptr_ff[AW-1:0] == rd_ptr_ff[AW-1:0]) && (wr_ptr_ff[AW] != rd_ptr_ff[AW]);
   assign head  = entry_ff[rd_ptr_ff[AW-1:0]];

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff[AW-1:0]] <= push_job;
      end
   end

endmodule

`default_nettype wire

>>> sv/crcfb_back.sv
// Back end of the frame builder: walks the job at the head of the queue one output
// byte per cycle into the result register while not stalled. Uses crcfb_pkg.
`default_nettype none

module crcfb_back
   import crcfb_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    empty,
   input  wire job_type head,
   output logic         pop,
   output logic         rsp_tvalid,
   input  wire logic    rsp_tready,
   output logic [7:0]   rsp_tdata,
   output logic         rsp_tlast,
   output logic [1:0]   rsp_tuser
);

   logic       active_ff, active_in;
   logic [2:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       done_ff, done_in;
   logic       rej_ff, rej_in;

   logic       load;
   logic       emit;
   logic [2:0] first_step;
   logic [2:0] last_step;
   logic [2:0] cur_step;
   logic       final_beat;
   logic       is_reject;
   logic [7:0] step_byte;

   always_comb begin
      is_reject  = 1'b0;
      first_step = STEP_BYTE1;
      last_step  = STEP_BYTE1;
      unique case (head.kind)
         JOB_REJECT: begin
            is_reject = 1'b1;
         end
         JOB_OPEN: begin
            first_step = STEP_HEAD_A;
         end
         JOB_OPEN_CLOSE: begin
            first_step = STEP_HEAD_A;
            last_step  = STEP_TAIL_B;
         end
         JOB_BYTE: begin
         end
         JOB_BYTE_CLOSE: begin
            last_step = STEP_TAIL_B;
         end
         default: begin
         end
      endcase
   end

   assign cur_step   = active_ff ? step_ff : first_step;
   assign final_beat = is_reject || (cur_step == last_step);

   always_comb begin
      unique case (cur_step)
         STEP_HEAD_A: step_byte = MARK_A;
         STEP_HEAD_B: step_byte = MARK_B;
         STEP_BYTE0:  step_byte = head.byte0;
         STEP_BYTE1:  step_byte = head.byte1;
         STEP_CRC_LO: step_byte = head.crc[7:0];
         STEP_CRC_HI: step_byte = head.crc[15:8];
         STEP_TAIL_A: step_byte = MARK_B;
         STEP_TAIL_B: step_byte = MARK_A;
         default:     step_byte = MARK_A;
      endcase
   end

   // A waiting job refills the result register when it is empty or being drained.
   assign load = !valid_ff || rsp_tready;
   assign emit = !empty && load;
   assign pop  = emit && final_beat;

   always_comb begin
      active_in = active_ff;
      step_in   = step_ff;
      valid_in  = valid_ff && !rsp_tready;
      byte_in   = byte_ff;
      last_in   = last_ff;
      done_in   = done_ff;
      rej_in    = rej_ff;
      if (emit) begin
         valid_in = 1'b1;
         byte_in  = is_reject ? 8'h00 : step_byte;
         last_in  = final_beat;
         done_in  = !is_reject && (cur_step == STEP_TAIL_B);
         rej_in   = is_reject;
         if (final_beat) begin
            active_in = 1'b0;
         end else begin
            active_in = 1'b1;
            step_in   = cur_step + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      done_ff <= done_in;
      rej_ff  <= rej_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = {rej_ff, done_ff};

endmodule

`default_nettype wire

>>> sv/crc16_frame_builder_unit.sv
// Top level of the CRC-16/MODBUS serial frame builder.
// Instantiates crcfb_front, crcfb_queue and crcfb_back; uses crcfb_pkg.
//
// A start beat (tuser 0) opens a frame and yields the head D5 5D, the command and
// the message type; each payload beat (tuser 1) yields its byte. After the last
// payload byte, or at the start when the length is zero, the CRC low and high
// bytes and the tail 5D D5 follow, the tail's final byte flagged as frame done.
// A start whose length plus eight exceeds the capacity register yields one
// rejection beat and no frame; payload beats with no frame open are taken and
// produce nothing. The front end takes one input beat per cycle while the job
// queue has room; the back end sends one byte per cycle unless stalled, so a
// start yields one, four or eight output bytes, a payload byte one or five, and
// the output rate sets the sustained input rate. There is no clearing pass after reset.
`default_nettype none

module crc16_frame_builder_unit
   import crcfb_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata,     // frame_capacity
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,     // command, message_type, payload_length, data_byte
   input  wire logic        req_tuser,     // opcode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,     // out_byte
   output logic             rsp_tlast,     // last_of_run
   output logic [1:0]       rsp_tuser      // frame_done, rejected
);

   logic    accept;
   logic    push;
   logic    pop;
   logic    full;
   logic    empty;
   job_type push_job;
   job_type head;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   crcfb_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .accept         (accept),
      .opcode         (req_tuser),
      .command        (req_tdata[7:0]),
      .message_type   (req_tdata[15:8]),
      .payload_length (req_tdata[31:16]),
      .data_byte      (req_tdata[39:32]),
      .push           (push),
      .job            (push_job)
   );

   crcfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (full),
      .empty    (empty),
      .head     (head)
   );

   crcfb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (empty),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire
